// ===== hdl/srt_pkg.sv =====
// Shared types, constants and helpers for the ascending integer sorter.
// No dependencies; imported by every module of the block.
package srt_pkg;

  localparam int unsigned Capacity = 64;   // cells in the chain, 2..64
  localparam int unsigned ElemW    = 32;   // stored element width, 8..64
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [CntW-1:0]         cnt_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } srt_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
  } srt_out_t;

  // chain-wide control for one cycle
  typedef struct packed {
    logic  insert;
    logic  shift;
    elem_t din;
  } srt_ctrl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  valid;
    logic  lt;      // incoming element sorts before this cell's element
    elem_t value;
  } srt_link_t;

  // keep the low ElemW bits as a signed number, or sign-extend when wider
  function automatic elem_t to_elem(logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ElemW-1:0];
  endfunction

  function automatic logic signed [31:0] from_elem(elem_t e);
    logic signed [63:0] w;
    w = 64'(e);
    return w[31:0];
  endfunction

endpackage

// ===== hdl/srt_cell.sv =====
// One cell of the sorting chain: holds one element and its valid bit.
// Depends on srt_pkg.
module srt_cell
  import srt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srt_ctrl_t ctrl_i,
  input  srt_link_t prev_i,
  input  srt_link_t next_i,
  output srt_link_t link_o
);

  logic  valid_q, valid_d;
  elem_t val_q, val_d;
  logic  lt;
  logic  take;

  assign lt   = valid_q && (ctrl_i.din < val_q);
  // open slot right after the occupied run also takes part in an insert
  assign take = lt || (!valid_q && prev_i.valid);

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    if (ctrl_i.insert && take) begin
      valid_d = 1'b1;
      val_d   = prev_i.lt ? prev_i.value : ctrl_i.din;
    end else if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      val_d   = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.lt    = lt;
  assign link_o.value = val_q;

endmodule

// ===== hdl/ascending_integer_sorter_top.sv =====
// Latency: the first sorted value is shown the cycle after the last input transfer.
// Throughput: one input transfer per cycle while collecting, one output transfer
// per cycle while draining a set of N values and out_stall_i is low (input stalled meanwhile),
// set by the compare-and-shift cell chain. Reset clears the cell valid bits,
// the element count and the drain flag; the chain starts empty.
module ascending_integer_sorter_top
  import srt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  srt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output srt_out_t out_data_o
);

  srt_ctrl_t ctrl;
  srt_link_t links [Capacity];
  srt_link_t prev_l [Capacity];
  srt_link_t next_l [Capacity];

  logic drain_q, drain_d;
  cnt_t count_q, count_d;
  logic in_xfer, out_xfer, set_done;

  assign in_stall_o  = drain_q;
  assign out_valid_o = drain_q;
  assign in_xfer     = in_valid_i && !drain_q;
  assign out_xfer    = drain_q && !out_stall_i;

  assign ctrl.insert = in_xfer;
  assign ctrl.shift  = out_xfer;
  assign ctrl.din    = to_elem(in_data_i.value);

  // a full store ends the set regardless of the marker
  assign set_done = in_data_i.last_in || (count_q == cnt_t'(Capacity - 1));

  for (genvar i = 0; i < Capacity; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign prev_l[i] = '{valid: 1'b1, lt: 1'b0, value: '0};
    end else begin : g_mid
      assign prev_l[i] = links[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign next_l[i] = '{valid: 1'b0, lt: 1'b0, value: '0};
    end else begin : g_body
      assign next_l[i] = links[i+1];
    end

    srt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev_l[i]),
      .next_i (next_l[i]),
      .link_o (links[i])
    );
  end

  assign out_data_o.sorted_value = from_elem(links[0].value);
  assign out_data_o.last_out     = !links[1].valid;

  always_comb begin
    drain_d = drain_q;
    count_d = count_q;
    if (in_xfer) begin
      if (set_done) begin
        drain_d = 1'b1;
        count_d = '0;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end else if (out_xfer && out_data_o.last_out) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      count_q <= '0;
    end else begin
      drain_q <= drain_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/srt_checker.sv =====
// Port-level checks for the sorter top level, attached by bind.
// Depends on srt_pkg and ascending_integer_sorter_top.
module srt_checker
  import srt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input srt_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input srt_out_t out_data_o
);

  // no input is taken while a set is being returned
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input not stalled during drain");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_in) |=> out_valid_o)
    else $error("no result after last input");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_out) |=>
      (out_valid_o &&
       ($signed(out_data_o.sorted_value) >= $signed($past(out_data_o.sorted_value)))))
    else $error("results not ascending or run broken");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_out) |=> !out_valid_o)
    else $error("output valid after final transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output changed");

endmodule

bind ascending_integer_sorter_top srt_checker u_srt_checker (.*);

// ===== tb/sv/ascending_integer_sorter_top_tb.sv =====
// Self-checking testbench for ascending_integer_sorter_top: sends sets of signed
// values and checks that each set comes back in ascending order with the end marked.
// Depends on srt_pkg and the RTL of the block; nothing else.
module ascending_integer_sorter_top_tb;
  import srt_pkg::*;

  typedef logic signed [31:0] word_t;
  typedef enum {FULL_RANGE, CLUSTERED, EDGE_VALUES} value_mix_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  srt_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  srt_out_t out_data_o;

  word_t       held_set[$];     // values collected for the set in progress
  srt_out_t    sorted_due[$];   // sorted values still to come out
  srt_out_t    want;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  ascending_integer_sorter_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // keep ElemW bits as a signed number
  function automatic word_t narrow_elem(word_t v);
    int sh;
    sh = (ElemW < 32) ? 32 - ElemW : 0;
    return (v <<< sh) >>> sh;
  endfunction

  // a set closes on its marked item or when it fills the store
  function automatic void collect_value(word_t v, logic last);
    word_t s[$];
    word_t t;
    int    j;
    held_set.push_back(narrow_elem(v));
    if (!last && held_set.size() < Capacity) return;
    s = held_set;
    for (int i = 1; i < s.size(); i++) begin
      t = s[i];
      j = i;
      while (j > 0 && t < s[j-1]) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    foreach (s[k]) begin
      sorted_due.push_back(srt_out_t'{sorted_value: s[k], last_out: (k == s.size() - 1)});
    end
    held_set.delete();
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: value %0d last %0b",
                   out_data_o.sorted_value, out_data_o.last_out);
      end else begin
        want = sorted_due.pop_front();
        if (out_data_o.sorted_value !== want.sorted_value ||
            out_data_o.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.sorted_value, want.last_out,
                     out_data_o.sorted_value, out_data_o.last_out);
        end
      end
    end
  end

  // called and left at a falling edge; valid stays high between back-to-back transfers
  task automatic send_value(word_t v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{value: v, last_in: last};
    do @(posedge clk_i); while (in_stall_o);
    collect_value(v, last);
    @(negedge clk_i);
  endtask

  task automatic send_set(word_t vals[$]);
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_all_sorted();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sorted_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic word_t pick_value(value_mix_e mix);
    case (mix)
      CLUSTERED: return word_t'(int'($urandom_range(8)) - 4);
      EDGE_VALUES: begin
        case ($urandom_range(5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh8000_0001;
          2:       return 32'sh7fff_ffff;
          3:       return 32'sh7fff_fffe;
          4:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_set('{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1});
    send_set('{32'sh8000_0000});
    send_set('{32'sh7fff_ffff});
    send_set('{32'sh5555_5555, 32'shaaaa_aaaa});
  endtask

  task automatic test_order_and_duplicates();
    send_set('{32'sd3, -32'sd3, 32'sd3, 32'sd3, -32'sd3});
    send_set('{32'sd7, 32'sd7});
    send_set('{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1});
  endtask

  // filling the store ends a set even with last_in low
  task automatic test_capacity_fill();
    for (int i = 0; i < Capacity; i++) send_value(pick_value(FULL_RANGE), 1'b0);
    send_set('{-32'sd9, 32'sd9});
    for (int i = 0; i < Capacity; i++) send_value(pick_value(CLUSTERED), i == Capacity - 1);
  endtask

  task automatic test_random_sets(int unsigned budget);
    int unsigned sent;
    int unsigned set_len;
    int unsigned roll;
    logic        marked;
    value_mix_e  mix;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 70)      set_len = $urandom_range(8, 1);
      else if (roll < 90) set_len = $urandom_range(40, 9);
      else                set_len = $urandom_range(Capacity, 41);
      mix    = value_mix_e'($urandom_range(2));
      marked = (set_len < Capacity) || $urandom_range(1);
      for (int i = 0; i < set_len; i++)
        send_value(pick_value(mix), marked && (i == set_len - 1));
      sent += set_len;
      if ($urandom_range(9) == 0) wait_all_sorted();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 8;
    recv_stall_pct = 78;
    test_extremes();
    test_order_and_duplicates();
    test_random_sets(80);
    wait_all_sorted();

    send_idle_pct  = 78;
    recv_stall_pct = 8;
    test_capacity_fill();
    test_random_sets(80);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sets(80);

    wait_all_sorted();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && sorted_due.size() == 0)
      $display("ascending_integer_sorter_top regression: pass");
    else
      $display("ascending_integer_sorter_top regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("ascending_integer_sorter_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/srt_pkg.sv
hdl/srt_cell.sv
hdl/ascending_integer_sorter_top.sv
hdl/srt_checker.sv
tb/sv/ascending_integer_sorter_top_tb.sv
